// File: sv/lmcs_pkg.sv
// Shared constants, codes and types of the LED matrix column scanner.
package lmcs_pkg;

   localparam int COLUMNS = 20;
   localparam int ROWS    = 20;

   localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int WORD_W = 40;
   localparam int CLIP_W = 5;
   localparam int COORD_W = 16;
   localparam int COLOUR_W = 16;
   localparam int SHOWN_W = 5;
   localparam int CSR_INDEX_W = 1;

   localparam logic [COLOUR_W-1:0] LIGHT_THRESHOLD = 16'h008F;
   localparam logic [CLIP_W-1:0]   CLIP_RESET      = CLIP_W'(20);

   localparam logic [WORD_W-1:0] ROW_MASK    = (WORD_W'(1) << ROWS) - WORD_W'(1);
   localparam logic [WORD_W-1:0] SELECT_MASK = ~ROW_MASK;

   typedef enum logic [1:0] {
      KIND_PIXEL = 2'd0,
      KIND_TICK  = 2'd1,
      KIND_BLANK = 2'd2
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CLIP_WIDTH  = 1'b0,
      CSR_CLIP_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic             wr_en;
      logic [COL_W-1:0] wr_col;
      logic [ROW_W-1:0] wr_row;
      logic             wr_set;
      logic             tick;
   } store_ctrl_type;

   typedef struct packed {
      logic [COL_W-1:0] column;
      logic [ROWS-1:0]  rows;
   } store_status_type;

endpackage

// File: sv/lmcs_req_if.sv
// Request channel: pixel writes, scan ticks and blank requests.
interface lmcs_req_if import lmcs_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [1:0]                 kind;
   logic signed [COORD_W-1:0]  pixel_x;
   logic signed [COORD_W-1:0]  pixel_y;
   logic [COLOUR_W-1:0]        colour;

   modport source (output valid, kind, pixel_x, pixel_y, colour, input ready);
   modport sink   (input valid, kind, pixel_x, pixel_y, colour, output ready);
endinterface

// File: sv/lmcs_rsp_if.sv
// Result channel: latch words for the column drivers.
interface lmcs_rsp_if import lmcs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [WORD_W-1:0]  latch_word;
   logic [SHOWN_W-1:0] column_shown;

   modport source (output valid, latch_word, column_shown, input ready);
   modport sink   (input valid, latch_word, column_shown, output ready);
endinterface

// File: sv/lmcs_frame_store.sv
// Double-buffered pixel stores and the scan column counter.
module lmcs_frame_store import lmcs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  store_ctrl_type   ctrl,
   output store_status_type status
);

   logic [ROWS-1:0]  drawing_ff [COLUMNS];
   logic [ROWS-1:0]  drawing_in [COLUMNS];
   logic [ROWS-1:0]  shown_ff   [COLUMNS];
   logic [ROWS-1:0]  shown_in   [COLUMNS];
   logic [COL_W-1:0] column_ff;
   logic [COL_W-1:0] column_in;
   logic             last_col;

   assign last_col = (column_ff == COL_W'(COLUMNS - 1));

   always_comb begin
      drawing_in = drawing_ff;
      shown_in   = shown_ff;
      column_in  = column_ff;
      if (ctrl.wr_en) begin
         drawing_in[ctrl.wr_col][ctrl.wr_row] = ctrl.wr_set;
      end
      if (ctrl.tick) begin
         if (last_col) begin
            column_in = '0;
            // swap happens on the tick only, so a pixel write never shares this cycle
            shown_in  = drawing_ff;
         end else begin
            column_in = column_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         for (int c = 0; c < COLUMNS; c++) begin
            drawing_ff[c] <= '0;
            shown_ff[c]   <= '0;
         end
      end else begin
         column_ff  <= column_in;
         drawing_ff <= drawing_in;
         shown_ff   <= shown_in;
      end
   end

   assign status.column = column_ff;
   assign status.rows   = shown_ff[column_ff];

endmodule

// File: sv/lmcs_rsp_reg.sv
// Result register in front of the result channel.
module lmcs_rsp_reg import lmcs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  logic [WORD_W-1:0]  word,
   input  logic [SHOWN_W-1:0] shown,
   output logic               can_load,
   lmcs_rsp_if.source         rsp_stream
);

   logic               valid_ff;
   logic               valid_in;
   logic [WORD_W-1:0]  word_ff;
   logic [SHOWN_W-1:0] shown_ff;

   assign can_load = !valid_ff || rsp_stream.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_stream.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff  <= word;
         shown_ff <= shown;
      end
   end

   assign rsp_stream.valid        = valid_ff;
   assign rsp_stream.latch_word   = word_ff;
   assign rsp_stream.column_shown = shown_ff;

endmodule

// File: sv/led_matrix_column_scan.sv
// Path: a request is captured in the request register, then its latch word is loaded into the result register.
// Throughput: one request per cycle while the result channel takes words as they come;
//   the rate is set by the single request register feeding the result register.
// A stalled result holds one request in the request register; a second waits upstream.
// Reset (synchronous) clears both pixel stores, the scan column and the channels;
//   the clip registers return to 20.
module led_matrix_column_scan import lmcs_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CLIP_W-1:0]      csr_write_data,
   lmcs_req_if.sink               req_stream,
   lmcs_rsp_if.source             rsp_stream
);

   logic [CLIP_W-1:0] clip_width_ff;
   logic [CLIP_W-1:0] clip_height_ff;

   logic                      s1_valid_ff;
   logic                      s1_valid_in;
   logic [1:0]                kind_ff;
   logic signed [COORD_W-1:0] pixel_x_ff;
   logic signed [COORD_W-1:0] pixel_y_ff;
   logic [COLOUR_W-1:0]       colour_ff;

   logic             req_accept;
   logic             emits;
   logic             advance;
   logic             can_load;
   logic             in_window;
   logic [COORD_W-2:0] x_mag;
   logic [COORD_W-2:0] y_mag;
   logic [5:0]       sel_shift;
   logic [WORD_W-1:0]  word;
   logic [SHOWN_W-1:0] shown;
   store_ctrl_type   store_ctrl;
   store_status_type store_status;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         clip_width_ff  <= CLIP_RESET;
         clip_height_ff <= CLIP_RESET;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_CLIP_WIDTH:  clip_width_ff  <= csr_write_data;
            CSR_CLIP_HEIGHT: clip_height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // request register
   always_comb begin
      case (kind_type'(kind_ff))
         KIND_TICK:  emits = 1'b1;
         KIND_BLANK: emits = 1'b1;
         default:    emits = 1'b0;
      endcase
   end

   assign advance          = s1_valid_ff && (!emits || can_load);
   assign req_stream.ready = !s1_valid_ff || advance;
   assign req_accept       = req_stream.valid && req_stream.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff    <= req_stream.kind;
         pixel_x_ff <= req_stream.pixel_x;
         pixel_y_ff <= req_stream.pixel_y;
         colour_ff  <= req_stream.colour;
      end
   end

   // pixel clipping: negative coordinates have the sign bit set
   assign x_mag = pixel_x_ff[COORD_W-2:0];
   assign y_mag = pixel_y_ff[COORD_W-2:0];
   assign in_window = !pixel_x_ff[COORD_W-1] && !pixel_y_ff[COORD_W-1]
                    && (x_mag < (COORD_W-1)'(clip_width_ff))
                    && (y_mag < (COORD_W-1)'(clip_height_ff))
                    && (x_mag < (COORD_W-1)'(COLUMNS))
                    && (y_mag < (COORD_W-1)'(ROWS));

   always_comb begin
      store_ctrl.wr_en  = advance && (kind_type'(kind_ff) == KIND_PIXEL) && in_window;
      store_ctrl.wr_col = x_mag[COL_W-1:0];
      store_ctrl.wr_row = y_mag[ROW_W-1:0];
      store_ctrl.wr_set = (colour_ff >= LIGHT_THRESHOLD);
      store_ctrl.tick   = advance && (kind_type'(kind_ff) == KIND_TICK);
   end

   lmcs_frame_store u_store (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (store_ctrl),
      .status (store_status)
   );

   // latch word: column 0 selects bit 39, active low
   assign sel_shift = 6'(WORD_W - 1) - 6'(store_status.column);

   always_comb begin
      if (kind_type'(kind_ff) == KIND_TICK) begin
         word  = (SELECT_MASK & ~(WORD_W'(1) << sel_shift))
               | WORD_W'(store_status.rows);
         shown = SHOWN_W'(store_status.column);
      end else begin
         word  = SELECT_MASK;
         shown = '0;
      end
   end

   lmcs_rsp_reg u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && emits),
      .word       (word),
      .shown      (shown),
      .can_load   (can_load),
      .rsp_stream (rsp_stream)
   );

`ifndef SYNTHESIS
   a_col_wrap: assert property (@(posedge clock) disable iff (reset)
      (store_ctrl.tick && store_status.column == COL_W'(COLUMNS - 1))
      |=> (store_status.column == '0))
      else $error("scan column did not wrap after the last column");

   a_col_step: assert property (@(posedge clock) disable iff (reset)
      (store_ctrl.tick && store_status.column != COL_W'(COLUMNS - 1))
      |=> (store_status.column == COL_W'($past(store_status.column) + COL_W'(1))))
      else $error("scan column did not advance by one");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance)
      |=> (s1_valid_ff && $stable(kind_ff) && $stable(pixel_x_ff)))
      else $error("stalled request was lost or changed");

   a_result_out: assert property (@(posedge clock) disable iff (reset)
      (advance && emits) |=> rsp_stream.valid)
      else $error("emitting request gave no result");
`endif

endmodule
